FILE: design/pbenc_pkg.sv
// ----------------------------------------------------------------------------
// pbenc_pkg
// Shared types and constants for the protobuf scalar value encoder.
// ----------------------------------------------------------------------------
package pbenc_pkg;

   // kind selector codes
   localparam logic [2:0] FUNC_INT32  = 3'd0;
   localparam logic [2:0] FUNC_UINT32 = 3'd1;
   localparam logic [2:0] FUNC_VAR64  = 3'd2;
   localparam logic [2:0] FUNC_BOOL   = 3'd3;
   localparam logic [2:0] FUNC_LE32   = 3'd4;
   localparam logic [2:0] FUNC_LE64   = 3'd5;
   localparam logic [2:0] FUNC_BYTE   = 3'd6;
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   localparam int unsigned BUFFER_BYTES_DEFAULT = 65536;
   localparam int unsigned OFFSET_REACH         = 65536;

   localparam int unsigned SIZE_WIDTH   = 17;
   localparam int unsigned OFFSET_WIDTH = 16;

   localparam logic [6:0] VARINT_MASK = 7'h7f;
   localparam logic [7:0] BYTE_MASK   = 8'hff;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]              byte_value;
      logic [OFFSET_WIDTH-1:0] byte_offset;
      logic                    dropped;
      logic                    last;
      logic [SIZE_WIDTH-1:0]   space_left;
   } rsp_payload_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef enum logic {
      MODE_VARINT,
      MODE_RAW
   } mode_type;

endpackage

FILE: design/protobuf_scalar_value_encoder_unit.sv
// ----------------------------------------------------------------------------
// protobuf_scalar_value_encoder_unit
// Turns one scalar per transaction into its protobuf wire bytes, one result
// transaction per byte, and tracks the write position in the output buffer.
// An accepted transaction is loaded into a 64-bit shift register, which is
// then shifted out one varint group (7 bits) or one raw byte per cycle while
// rsp_stall does not hold the output register: 1 byte for bool and raw byte,
// 4 for le32, 8 for le64, 1 to 5 for positive int32 and uint32, 1 to 10 for
// 64-bit varints and always 10 for negative int32. The input is stalled
// until the last byte of an item has been shifted out. The shift register
// serves one item at a time; the next item is taken in the cycle after the
// last byte of the current one moves into the output register. A selector
// of 7 is taken without leaving the idle state and yields no bytes.
// Writing the size register (accepted only while no item is being shifted
// out) clears the write position. Once the position reaches the buffer size,
// bytes come out flagged as dropped with offset and space 0.
// ----------------------------------------------------------------------------
module protobuf_scalar_value_encoder_unit
   import pbenc_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_WIDTH-1:0] csr_data
);

   localparam logic [SIZE_WIDTH-1:0] SIZE_LIMIT = (BUFFER_BYTES > OFFSET_REACH) ?
      SIZE_WIDTH'(OFFSET_REACH) : SIZE_WIDTH'(BUFFER_BYTES);

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [63:0]           data_ff, data_in;
   logic [3:0]            count_ff, count_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;
   logic [SIZE_WIDTH-1:0] pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic                  csr_take;
   logic                  load_known;
   logic                  emit;
   logic                  emit_last;
   logic [7:0]            emit_byte;
   logic                  full;
   logic [SIZE_WIDTH-1:0] pos_next;

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;
   assign load_known = (req_data.func != FUNC_UNUSED);
   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign full = (pos_ff >= size_ff);
   assign pos_next = pos_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && load_known) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      csr_ready = (state_ff == ST_IDLE);

      case (mode_ff)
         MODE_VARINT: begin
            emit_last = ~|data_ff[63:7];
            emit_byte = {~emit_last, data_ff[6:0] & VARINT_MASK};
         end
         MODE_RAW: begin
            emit_last = (count_ff == 4'd1);
            emit_byte = data_ff[7:0] & BYTE_MASK;
         end
         default: begin
            emit_last = 1'b1;
            emit_byte = data_ff[7:0];
         end
      endcase

      mode_in  = mode_ff;
      data_in  = data_ff;
      count_in = count_ff;
      if (req_take) begin
         case (req_data.func)
            FUNC_INT32: begin
               mode_in  = MODE_VARINT;
               count_in = 4'd0;
               data_in  = {{32{req_data.value[31]}}, req_data.value[31:0]};
            end
            FUNC_UINT32: begin
               mode_in  = MODE_VARINT;
               count_in = 4'd0;
               data_in  = {32'd0, req_data.value[31:0]};
            end
            FUNC_VAR64: begin
               mode_in  = MODE_VARINT;
               count_in = 4'd0;
               data_in  = req_data.value;
            end
            FUNC_BOOL: begin
               mode_in  = MODE_RAW;
               count_in = 4'd1;
               data_in  = {63'd0, |req_data.value};
            end
            FUNC_LE32: begin
               mode_in  = MODE_RAW;
               count_in = 4'd4;
               data_in  = {32'd0, req_data.value[31:0]};
            end
            FUNC_LE64: begin
               mode_in  = MODE_RAW;
               count_in = 4'd8;
               data_in  = req_data.value;
            end
            FUNC_BYTE: begin
               mode_in  = MODE_RAW;
               count_in = 4'd1;
               data_in  = {56'd0, req_data.value[7:0]};
            end
            default: begin
               mode_in  = mode_ff;
               count_in = count_ff;
               data_in  = data_ff;
            end
         endcase
      end else if (emit) begin
         if (mode_ff == MODE_VARINT) begin
            data_in = {7'd0, data_ff[63:7]};
         end else begin
            data_in  = {8'd0, data_ff[63:8]};
            count_in = count_ff - 4'd1;
         end
      end

      size_in = size_ff;
      pos_in  = pos_ff;
      if (csr_take) begin
         size_in = (csr_data > SIZE_LIMIT) ? SIZE_LIMIT : csr_data;
         pos_in  = '0;
      end else if (emit && !full) begin
         pos_in = pos_next;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.byte_value = emit_byte;
         rsp_data_in.last       = emit_last;
         rsp_data_in.dropped    = full;
         if (full) begin
            rsp_data_in.byte_offset = '0;
            rsp_data_in.space_left  = '0;
         end else begin
            rsp_data_in.byte_offset = pos_ff[OFFSET_WIDTH-1:0];
            rsp_data_in.space_left  = size_ff - pos_next;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_LIMIT;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         mode_ff      <= MODE_RAW;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/pbenc_checker.sv
// ----------------------------------------------------------------------------
// pbenc_checker
// Port-level checks for the protobuf scalar value encoder.
// ----------------------------------------------------------------------------
module pbenc_checker
   import pbenc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_payload_type       req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_payload_type       rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [SIZE_WIDTH-1:0] csr_data
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a dropped byte reports no offset and no space
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> rsp_data.byte_offset == '0 &&
         rsp_data.space_left == '0)
      else $error("dropped byte with offset or space");

   // an item that produces bytes keeps the input busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.func != FUNC_UNUSED |=> req_stall && !csr_ready)
      else $error("input free right after a producing transaction");

   // while a non-final byte is shown, the item is still being shifted out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("input free before the last byte");

endmodule

bind protobuf_scalar_value_encoder_unit pbenc_checker u_pbenc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);
